@@ rtl/ge_pkg.sv @@
// gamma encode/decode package: pipeline side-band type, register indexes,
// log2 rom and the constant functions shared by the log2 stage and the top level
`default_nettype none

package ge_pkg;

    localparam int BASE_BITS = 6;
    localparam longint ROUND_BIAS = 64'sh10D;

    // register indexes of the configuration port
    localparam logic [0:0] CFG_DECODE_EXP = 1'b0;
    localparam logic [0:0] CFG_ENCODE_EXP = 1'b1;

    // per-beat control that travels with the data
    typedef struct packed {
        logic valid;
        logic action;   // 0 decode, 1 encode
        logic zero;     // result forced to 0
    } t_side;

    // log2(1 + j/64) in Q31
    localparam logic [31:0] BASE_ROM [0:65] = '{
        32'h00000000, 32'h02dcf2d1, 32'h05aeb4dd, 32'h08759c50, 32'h0b31fb7d, 32'h0de42120,
        32'h108c588d, 32'h132ae9e2, 32'h15c01a3a, 32'h184c2bd0, 32'h1acf5e2e, 32'h1d49ee4c,
        32'h1fbc16b9, 32'h22260fb6, 32'h24880f56, 32'h26e2499d, 32'h2934f098, 32'h2b803474,
        32'h2dc4439b, 32'h30014ac6, 32'h32377512, 32'h3466ec15, 32'h368fd7ee, 32'h38b25f5a,
        32'h3acea7c0, 32'h3ce4d544, 32'h3ef50ad2, 32'h40ff6a2e, 32'h43041403, 32'h450327eb,
        32'h46fcc47a, 32'h48f10751, 32'h4ae00d1d, 32'h4cc9f1ab, 32'h4eaecfeb, 32'h508ec1fa,
        32'h5269e12f, 32'h5440461c, 32'h5612089a, 32'h57df3fd0, 32'h59a80239, 32'h5b6c65aa,
        32'h5d2c7f59, 32'h5ee863e5, 32'h60a02757, 32'h6253dd2c, 32'h64039858, 32'h65af6b4b,
        32'h675767f5, 32'h68fb9fce, 32'h6a9c23d6, 32'h6c39049b, 32'h6dd2523d, 32'h6f681c73,
        32'h70fa728c, 32'h72896373, 32'h7414fdb5, 32'h759d4f81, 32'h772266ad, 32'h78a450b8,
        32'h7a231ace, 32'h7b9ed1c7, 32'h7d17822f, 32'h7e8d3846, 32'h80000000, 32'h816fe50b
    };

    // rom entry j for a table of 2^lib steps
    function automatic logic [32:0] rom_entry(input logic [8:0] j, input int lib);
        int down;
        int up;
        int p;
        int q;
        longint lo;
        longint hi;
        longint rem;
        down = BASE_BITS - lib;
        rom_entry = '0;
        if (down >= 0) begin
            p = int'(j) << down;
            if (p <= 65) begin
                rom_entry = {1'b0, BASE_ROM[p]};
            end else begin
                p = (p - 64) >> 1;
                if (p > 65) begin
                    p = 65;
                end
                rom_entry = {1'b0, 32'h80000000} + {1'b0, BASE_ROM[p]};
            end
        end else begin
            up = -down;
            q = int'(j) >> up;
            rem = longint'(int'(j) & ((1 << up) - 1));
            if (q > 64) begin
                q = 64;
            end
            lo = longint'(BASE_ROM[q]);
            hi = longint'(BASE_ROM[q + 1]);
            rom_entry = 33'(lo + (((hi - lo) * rem) >>> up));
        end
    endfunction

    // log2 of a nonzero Q16 value, evaluated at elaboration only
    function automatic longint log2_const(input longint u, input int lib);
        int lz;
        int fs;
        longint t;
        longint idx;
        longint dx;
        longint y0;
        longint f1;
        longint f2;
        longint a;
        longint b;
        longint q;
        longint m;
        lz = 0;
        for (int k = 31; k >= 0; k--) begin
            if (u[k]) begin
                break;
            end
            lz++;
        end
        fs = 32 - lib;
        t = (u << (lz + 1)) & 64'hFFFFFFFF;
        idx = t >> fs;
        dx = t & ((64'sd1 << fs) - 1);
        y0 = longint'(rom_entry(9'(idx), lib));
        f1 = longint'(rom_entry(9'(idx + 1), lib)) - y0;
        f2 = longint'(rom_entry(9'(idx + 2), lib)) - y0;
        a = f2 - 2 * f1;
        b = 2 * f1 - a;
        q = ((a * dx) >>> fs) + b;
        q = (q * dx) >>> (fs + 1);
        m = (y0 + q) & 64'hFFFFFFFF;
        m = ((m + 64'h4000 + ROUND_BIAS) & 64'hFFFFFFFF) >> 15;
        log2_const = longint'(15 - lz) * 65536 + m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ge_in_if.sv @@
// input channel of the gamma converter: valid/ready with action and sample
// no dependencies
`default_nettype none

interface ge_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [16:0] sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

`default_nettype wire

@@ rtl/ge_out_if.sv @@
// output channel of the gamma converter: valid/ready with converted value
// no dependencies
`default_nettype none

interface ge_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] converted;

    modport source (output valid, output converted, input ready);
    modport sink   (input valid, input converted, output ready);
endinterface

`default_nettype wire

@@ rtl/ge_log2.sv @@
// four-stage Q16 log2: leading-zero count, rom lookup, two interpolation steps
// depends on ge_pkg
`default_nettype none

module ge_log2 #(
    parameter int LIB = 6
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire ge_pkg::t_side  i_side,
    input  wire [31:0]          i_u,
    output ge_pkg::t_side       o_side,
    output logic signed [23:0]  o_log
);
    localparam int FS = 32 - LIB;

    // stage a: normalize count
    ge_pkg::t_side r_a_side;
    logic [31:0]   r_a_u;
    logic [4:0]    r_a_lz;
    logic [4:0]    n_lz;

    always_comb begin
        n_lz = 5'd31;
        for (int k = 0; k < 32; k++) begin
            if (i_u[k]) begin
                n_lz = 5'(31 - k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
        end else if (i_en) begin
            r_a_side <= i_side;
        end
        if (i_en) begin
            r_a_u  <= i_u;
            r_a_lz <= n_lz;
        end
    end

    // stage b: rom lookup and parabola coefficients
    logic [31:0]        w_tn;
    logic [31:0]        w_t;
    logic [8:0]         w_idx;
    logic signed [34:0] w_y0;
    logic signed [34:0] w_y1;
    logic signed [34:0] w_y2;
    logic signed [35:0] w_f1;
    logic signed [35:0] w_f2;
    logic signed [35:0] w_a;

    assign w_tn  = r_a_u << r_a_lz;
    assign w_t   = {w_tn[30:0], 1'b0};
    assign w_idx = 9'(w_t[31:FS]);
    assign w_y0  = $signed({2'b00, ge_pkg::rom_entry(w_idx, LIB)});
    assign w_y1  = $signed({2'b00, ge_pkg::rom_entry(w_idx + 9'd1, LIB)});
    assign w_y2  = $signed({2'b00, ge_pkg::rom_entry(w_idx + 9'd2, LIB)});
    assign w_f1  = 36'(w_y1) - 36'(w_y0);
    assign w_f2  = 36'(w_y2) - 36'(w_y0);
    assign w_a   = w_f2 - (w_f1 <<< 1);

    ge_pkg::t_side      r_b_side;
    logic signed [34:0] r_b_y0;
    logic signed [35:0] r_b_a;
    logic signed [36:0] r_b_b;
    logic [FS-1:0]      r_b_dx;
    logic signed [6:0]  r_b_ip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_side <= '0;
        end else if (i_en) begin
            r_b_side <= r_a_side;
        end
        if (i_en) begin
            r_b_y0 <= w_y0;
            r_b_a  <= w_a;
            r_b_b  <= (37'(w_f1) <<< 1) - 37'(w_a);
            r_b_dx <= w_t[FS-1:0];
            r_b_ip <= 7'sd15 - $signed({2'b00, r_a_lz});
        end
    end

    // stage c: first interpolation step
    logic signed [FS:0]      w_dxs_b;
    logic signed [FS+36:0]   w_ad;
    assign w_dxs_b = $signed({1'b0, r_b_dx});
    assign w_ad    = (FS + 37)'(r_b_a) * (FS + 37)'(w_dxs_b);

    ge_pkg::t_side      r_c_side;
    logic signed [34:0] r_c_y0;
    logic signed [37:0] r_c_q;
    logic [FS-1:0]      r_c_dx;
    logic signed [6:0]  r_c_ip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side <= '0;
        end else if (i_en) begin
            r_c_side <= r_b_side;
        end
        if (i_en) begin
            r_c_y0 <= r_b_y0;
            r_c_q  <= 38'(w_ad >>> FS) + 38'(r_b_b);
            r_c_dx <= r_b_dx;
            r_c_ip <= r_b_ip;
        end
    end

    // stage d: second step, rounding to Q16
    logic signed [FS:0]    w_dxs_c;
    logic signed [FS+38:0] w_qd;
    logic signed [38:0]    w_q2;
    logic [31:0]           w_m32;
    logic [31:0]           w_mr;
    logic [16:0]           w_m;

    assign w_dxs_c = $signed({1'b0, r_c_dx});
    assign w_qd    = (FS + 39)'(r_c_q) * (FS + 39)'(w_dxs_c);
    assign w_q2    = 39'(w_qd >>> (FS + 1));
    assign w_m32   = 32'(39'(r_c_y0) + w_q2);
    assign w_mr    = w_m32 + 32'h4000 + 32'(ge_pkg::ROUND_BIAS);
    assign w_m     = w_mr[31:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side <= '0;
        end else if (i_en) begin
            o_side <= r_c_side;
        end
        if (i_en) begin
            o_log <= $signed({r_c_ip[6], r_c_ip, 16'h0000}) + $signed({7'b0, w_m});
        end
    end

endmodule

`default_nettype wire

@@ rtl/ge_exp2.sv @@
// three-stage Q16 exp2: split into integer and fraction, cubic in Horner form,
// final shift by the integer part; depends on ge_pkg
`default_nettype none

module ge_exp2 (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire ge_pkg::t_side  i_side,
    input  wire signed [35:0]   i_x,
    output ge_pkg::t_side       o_side,
    output logic [31:0]         o_e
);
    // stage f: n = round(x), f in [-0.5, 0.5), first horner step
    logic signed [35:0] w_xs;
    logic signed [19:0] w_n;
    logic signed [20:0] w_s;
    logic signed [16:0] w_f;
    logic signed [33:0] w_r1;

    assign w_xs = i_x + 36'sh8000;
    assign w_n  = 20'(w_xs >>> 16);
    assign w_s  = 21'sd15 - 21'(w_n);
    assign w_f  = $signed({1'b0, w_xs[15:0]}) - 17'sd32768;
    assign w_r1 = (34'sd3616 * 34'(w_f) + 34'sh3E1CC333) >>> 17;

    ge_pkg::t_side      r_f_side;
    logic signed [16:0] r_f_f;
    logic signed [16:0] r_f_r;
    logic               r_f_out;
    logic [4:0]         r_f_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_side <= '0;
        end else if (i_en) begin
            r_f_side <= i_side;
        end
        if (i_en) begin
            r_f_f   <= w_f;
            r_f_r   <= 17'(w_r1);
            // shift of 32 or more empties the value; negative shift acts as none
            r_f_out <= (w_s >= 21'sd32);
            r_f_sh  <= (w_s < 21'sd0) ? 5'd0 : w_s[4:0];
        end
    end

    // stage g
    logic signed [33:0] w_r2;
    assign w_r2 = (34'(r_f_r) * 34'(r_f_f) + 34'sh58BD46A6) >>> 16;

    ge_pkg::t_side      r_g_side;
    logic signed [16:0] r_g_f;
    logic signed [18:0] r_g_r;
    logic               r_g_out;
    logic [4:0]         r_g_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_side <= '0;
        end else if (i_en) begin
            r_g_side <= r_f_side;
        end
        if (i_en) begin
            r_g_f   <= r_f_f;
            r_g_r   <= 19'(w_r2);
            r_g_out <= r_f_out;
            r_g_sh  <= r_f_sh;
        end
    end

    // stage h
    logic signed [37:0] w_m;
    logic [31:0]        w_m32;
    assign w_m   = 38'(r_g_r) * 38'(r_g_f) + 38'sh7FFDE4A3;
    assign w_m32 = w_m[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side <= '0;
        end else if (i_en) begin
            o_side <= r_g_side;
        end
        if (i_en) begin
            o_e <= r_g_out ? 32'd0 : (w_m32 >> r_g_sh);
        end
    end

endmodule

`default_nettype wire

@@ rtl/gamma_encode_decode_top.sv @@
// gamma 2.2 encode/decode: one pixel per clock when not stalled, fixed-point log2 then exp2
// depends on ge_pkg, ge_in_if, ge_out_if, ge_log2, ge_exp2
//
// usage:
//   i_px carries action (0 decode an 8-bit code, 1 encode Q16 linear light)
//   and sample; o_px carries converted. a beat moves when valid and ready
//   are both high. the exponents are written through i_cfg_we/i_cfg_idx/
//   i_cfg_data (index 0 decode exponent * 64, index 1 encode exponent * 1024)
//   while no beat is in flight.
//   nine register stages: 4 log2 stages, the exponent multiply, 3 exp2 stages
//   and the output register. the accepting edge loads the first one, and
//   output valid rises when the beat reaches the output register.
//   throughput is one beat per clock while the output does not stall; every stage holds one beat.
//   when o_px.ready is low with a result waiting, the whole pipeline holds
//   and i_px.ready drops; nothing is lost or repeated.
//   synchronous reset empties the pipeline and restores exponents 141 and 465.
`default_nettype none

module gamma_encode_decode_top #(
    parameter int LUT_INDEX_BITS = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [0:0]   i_cfg_idx,
    input  wire [9:0]   i_cfg_data,
    ge_in_if.sink       i_px,
    ge_out_if.source    o_px
);
    localparam longint L255 = ge_pkg::log2_const(64'd255 << 16, LUT_INDEX_BITS);

    logic [7:0] r_dec_exp;
    logic [9:0] r_enc_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_exp <= 8'd141;
            r_enc_exp <= 10'd465;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ge_pkg::CFG_DECODE_EXP: r_dec_exp <= i_cfg_data[7:0];
                ge_pkg::CFG_ENCODE_EXP: r_enc_exp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic          r_o_valid;
    logic [16:0]   r_o_conv;
    ge_pkg::t_side r_o_side;
    logic          w_en;

    assign w_en       = !r_o_valid || o_px.ready;
    assign i_px.ready = w_en;

    // input saturation and log2 argument
    ge_pkg::t_side w_in_side;
    logic [31:0]   w_u;
    logic [7:0]    w_code;
    logic [16:0]   w_lin;

    assign w_code = (i_px.sample > 17'd255) ? 8'd255 : i_px.sample[7:0];
    assign w_lin  = (i_px.sample > 17'd65536) ? 17'd65536 : i_px.sample;
    assign w_u    = i_px.action ? {15'd0, w_lin} : {8'd0, w_code, 16'd0};
    assign w_in_side.valid  = i_px.valid;
    assign w_in_side.action = i_px.action;
    assign w_in_side.zero   = (i_px.sample == 17'd0);

    ge_pkg::t_side     w_log_side;
    logic signed [23:0] w_log;

    ge_log2 #(.LIB(LUT_INDEX_BITS)) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_in_side),
        .i_u     (w_u),
        .o_side  (w_log_side),
        .o_log   (w_log)
    );

    // exponent multiply
    logic signed [24:0] w_diff;
    logic signed [35:0] w_prod;
    logic signed [35:0] w_t;

    assign w_diff = w_log_side.action ? 25'(w_log) : (25'(w_log) - 25'(L255));
    assign w_prod = 36'(w_diff) * (w_log_side.action ? $signed({26'd0, r_enc_exp})
                                                     : $signed({28'd0, r_dec_exp}));
    assign w_t    = w_log_side.action ? (w_prod >>> 10) : (w_prod >>> 6);

    ge_pkg::t_side      r_e_side;
    logic signed [35:0] r_e_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_side <= '0;
        end else if (w_en) begin
            r_e_side.valid  <= w_log_side.valid;
            r_e_side.action <= w_log_side.action;
            // decode at or below the cutoff goes to black
            r_e_side.zero   <= w_log_side.zero ||
                               (!w_log_side.action && (w_t <= -36'sd1154256));
        end
        if (w_en) begin
            r_e_t <= w_t;
        end
    end

    ge_pkg::t_side w_exp_side;
    logic [31:0]   w_e;

    ge_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (r_e_side),
        .i_x     (r_e_t),
        .o_side  (w_exp_side),
        .o_e     (w_e)
    );

    // gain and output scaling
    logic [46:0] w_g;
    logic [24:0] w_enc_v;
    logic [24:0] w_enc_m1;
    logic [16:0] w_res;

    assign w_g      = 47'd16386 * 47'(w_e);
    assign w_enc_v  = w_g[46:22];
    assign w_enc_m1 = (w_enc_v == 25'd0) ? 25'd0 : w_enc_v - 25'd1;

    always_comb begin
        if (w_exp_side.zero) begin
            w_res = 17'd0;
        end else if (w_exp_side.action) begin
            w_res = (w_enc_m1 > 25'd255) ? 17'd255 : w_enc_m1[16:0];
        end else begin
            w_res = (w_g[46:14] > 33'h1FFFF) ? 17'h1FFFF : w_g[30:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_o_side  <= '0;
        end else if (w_en) begin
            r_o_valid <= w_exp_side.valid;
            r_o_side  <= w_exp_side;
        end
        if (w_en) begin
            r_o_conv <= w_res;
        end
    end

    assign o_px.valid     = r_o_valid;
    assign o_px.converted = r_o_conv;

    a_enc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_side.action) |-> (r_o_conv <= 17'd255))
        else $error("encode result above 255");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_side.zero) |-> (r_o_conv == 17'd0))
        else $error("forced-zero beat gave nonzero result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_e_side) && $stable(r_e_t))
        else $error("pipeline moved during stall");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> (r_e_side.valid == $past(w_log_side.valid)))
        else $error("valid lost between log2 and multiply stage");

endmodule

`default_nettype wire
